### rtl/rbs_pkg.sv
// ----------------------------------------------------------------------------
// rbs_pkg
// Types, constants and control codes shared by the redundant baseline stacker.
// ----------------------------------------------------------------------------
package rbs_pkg;

	localparam int RBS_MAX_STACKS = 4096;
	localparam int RBS_IDX_W      = 12;
	localparam int RBS_SUM_W      = 48;
	localparam int RBS_CNT_W      = 16;
	localparam int RBS_DIVD_W     = 64;
	localparam int RBS_DIVR_W     = 48;

	localparam logic RBS_REQ_ACC   = 1'b0;
	localparam logic RBS_REQ_DRAIN = 1'b1;

	typedef struct packed {
		logic                 req_type;
		logic [11:0]          stack_index;
		logic signed [31:0]   vis_real;
		logic signed [31:0]   vis_imag;
		logic [31:0]          weight;
		logic                 conjugate_flip;
	} rbs_in_t;

	typedef struct packed {
		logic [11:0]          out_stack_index;
		logic signed [31:0]   mean_real;
		logic signed [31:0]   mean_imag;
		logic [31:0]          stack_weight;
		logic [15:0]          product_count;
	} rbs_out_t;

	typedef struct packed {
		logic [RBS_SUM_W-1:0] sum_real;
		logic [RBS_SUM_W-1:0] sum_imag;
		logic [RBS_SUM_W-1:0] var_sum;
		logic [RBS_CNT_W-1:0] count;
	} rbs_entry_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ACC_RD,
		ST_ACC_WR,
		ST_DRN_RD,
		ST_DRN_LATCH,
		ST_DIV_GO,
		ST_DIV_RUN,
		ST_FIN
	} rbs_state_t;

	typedef enum logic [1:0] {
		DIV_RCP,
		DIV_RE,
		DIV_IM,
		DIV_WT
	} rbs_div_t;

	typedef struct packed {
		logic     take;
		logic     clr_we;
		logic     rd;
		logic     acc_we;
		logic     latch;
		logic     div_start;
		logic     div_cap;
		rbs_div_t div_sel;
		logic     load_out;
	} rbs_cmd_t;

	typedef struct packed {
		logic is_drain;
		logic acc_skip;
		logic clr_last;
		logic div_busy;
		logic div_done;
	} rbs_stat_t;

endpackage

### rtl/redundant_baseline_stacker.sv
// ----------------------------------------------------------------------------
// redundant_baseline_stacker
// Averages complex visibilities of redundant baselines into stacks and drains
// each stack as mean visibility and combined weight.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | rbs_in_t  (accumulate or drain)
//  rsp     | out       | rsp_valid/rsp_ready  | rbs_out_t (one per drain)
//
//  After reset a clearing pass writes every stack entry, one per cycle;
//  no request is taken during it. Accumulate and drain both run on the
//  shared 64-step bit-serial divider (reciprocal for accumulate; two means
//  and the weight for drain); a skipped product does not use it.
//  A finished result waits in the output register while the next request
//  is taken; a drain stalls at its end only if that register is still full.
// ----------------------------------------------------------------------------
module redundant_baseline_stacker
	import rbs_pkg::*;
#(
	parameter int MAX_STACKS = RBS_MAX_STACKS
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  rbs_in_t  req,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output rbs_out_t rsp
);

	rbs_cmd_t  cmd;
	rbs_stat_t st;

	rbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.st        (st),
		.cmd       (cmd)
	);

	rbs_datapath #(
		.MAX_STACKS (MAX_STACKS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.st     (st),
		.rsp    (rsp)
	);

endmodule

### rtl/rbs_div.sv
// ----------------------------------------------------------------------------
// rbs_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rbs_div
	import rbs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [RBS_DIVD_W-1:0] dividend,
	input  logic [RBS_DIVR_W-1:0] divisor,
	output logic                  busy,
	output logic                  done,
	output logic [RBS_DIVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(RBS_DIVD_W);

	logic [RBS_DIVD_W-1:0] quo_q;
	logic [RBS_DIVR_W:0]   rem_q;
	logic [RBS_DIVR_W-1:0] dvs_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [RBS_DIVR_W:0]   trial;
	logic                  fits;

	// shift in the next dividend bit and try the subtract
	assign trial = {rem_q[RBS_DIVR_W-1:0], quo_q[RBS_DIVD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	// sequence the iterations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(RBS_DIVD_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// hold operands and partial results
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? (trial - {1'b0, dvs_q}) : trial;
			quo_q <= {quo_q[RBS_DIVD_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### rtl/rbs_datapath.sv
// ----------------------------------------------------------------------------
// rbs_datapath
// Stack memory, request and result registers, accumulate arithmetic and the
// shared divider.
// ----------------------------------------------------------------------------
module rbs_datapath
	import rbs_pkg::*;
#(
	parameter int MAX_STACKS = RBS_MAX_STACKS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  rbs_in_t   req,
	input  rbs_cmd_t  cmd,
	output rbs_stat_t st,
	output rbs_out_t  rsp
);

	localparam int DEPTH = (MAX_STACKS < (1 << RBS_IDX_W)) ? MAX_STACKS : (1 << RBS_IDX_W);
	localparam int AW    = $clog2(DEPTH);
	localparam logic [16:0] LIMIT = 17'(MAX_STACKS);

	rbs_entry_t            mem_q [DEPTH];
	rbs_entry_t            rdata_q;
	rbs_entry_t            ent_q;
	rbs_in_t               req_q;
	rbs_out_t              rsp_q;
	logic [AW-1:0]         clr_q;
	logic [31:0]           recip_q;
	logic [31:0]           mre_q;
	logic [31:0]           mim_q;
	logic [31:0]           wt_q;

	logic                  in_range_new;
	logic                  in_range_q;
	logic [AW-1:0]         addr;
	logic                  we;
	logic [AW-1:0]         waddr;
	rbs_entry_t            wdata;
	rbs_entry_t            acc_ent;
	logic [48:0]           sr49;
	logic [48:0]           si49;
	logic [48:0]           vs49;
	logic [32:0]           im33;
	logic [47:0]           mag_re;
	logic [47:0]           mag_im;
	logic [31:0]           c2;
	logic [RBS_DIVD_W-1:0] dvd;
	logic [RBS_DIVR_W-1:0] dvs;
	logic [RBS_DIVD_W-1:0] quo;
	logic                  div_busy;
	logic                  div_done;

	// saturate a signed quotient magnitude to 32 bits
	function automatic logic [31:0] mean_sat(input logic neg, input logic [63:0] q);
		logic [31:0] r;
		if (!neg) begin
			r = (q[63:31] != '0) ? 32'h7FFF_FFFF : q[31:0];
		end else begin
			r = (q > 64'h8000_0000) ? 32'h8000_0000 : (32'h0 - q[31:0]);
		end
		return r;
	endfunction

	assign in_range_new = {5'b0, req.stack_index} < LIMIT;
	assign in_range_q   = {5'b0, req_q.stack_index} < LIMIT;
	assign addr         = req_q.stack_index[AW-1:0];

	// capture the request
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			req_q <= req;
		end
	end

	// walk the clear pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_we) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// accumulate one product into the entry read back
	always_comb begin
		im33 = {req_q.vis_imag[31], req_q.vis_imag};
		if (req_q.conjugate_flip) begin
			im33 = 33'h0 - im33;
		end
		sr49 = {rdata_q.sum_real[47], rdata_q.sum_real} +
			{{17{req_q.vis_real[31]}}, req_q.vis_real};
		si49 = {rdata_q.sum_imag[47], rdata_q.sum_imag} + {{16{im33[32]}}, im33};
		vs49 = {1'b0, rdata_q.var_sum} + {17'b0, recip_q};
		acc_ent.sum_real = (sr49[48] != sr49[47]) ?
			(sr49[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}}) : sr49[47:0];
		acc_ent.sum_imag = (si49[48] != si49[47]) ?
			(si49[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}}) : si49[47:0];
		acc_ent.var_sum  = vs49[48] ? {48{1'b1}} : vs49[47:0];
		acc_ent.count    = (rdata_q.count == 16'hFFFF) ? rdata_q.count :
			(rdata_q.count + 16'd1);
	end

	// pick the memory write
	always_comb begin
		we    = cmd.clr_we | cmd.acc_we | (cmd.latch & in_range_q);
		waddr = cmd.clr_we ? clr_q : addr;
		wdata = cmd.acc_we ? acc_ent : '0;
	end

	// stack memory with registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (cmd.rd) begin
			rdata_q <= mem_q[addr];
		end
	end

	// latch the drained entry
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			ent_q <= in_range_q ? rdata_q : '0;
		end
	end

	// select divider operands
	always_comb begin
		mag_re = ent_q.sum_real[47] ? (48'h0 - ent_q.sum_real) : ent_q.sum_real;
		mag_im = ent_q.sum_imag[47] ? (48'h0 - ent_q.sum_imag) : ent_q.sum_imag;
		c2     = ent_q.count * ent_q.count;
		unique case (cmd.div_sel)
			DIV_RCP: begin
				dvd = 64'h1_0000_0000;
				dvs = {16'b0, req_q.weight};
			end
			DIV_RE: begin
				dvd = {16'b0, mag_re};
				dvs = {32'b0, ent_q.count};
			end
			DIV_IM: begin
				dvd = {16'b0, mag_im};
				dvs = {32'b0, ent_q.count};
			end
			default: begin
				dvd = {c2, 32'b0};
				dvs = ent_q.var_sum;
			end
		endcase
	end

	rbs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd),
		.divisor  (dvs),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quo)
	);

	// store each quotient, saturated
	always_ff @(posedge clk) begin
		if (cmd.div_cap) begin
			unique case (cmd.div_sel)
				DIV_RCP: recip_q <= (quo[63:32] != '0) ? 32'hFFFF_FFFF : quo[31:0];
				DIV_RE:  mre_q <= (ent_q.count == '0) ? 32'h0 :
					mean_sat(ent_q.sum_real[47], quo);
				DIV_IM:  mim_q <= (ent_q.count == '0) ? 32'h0 :
					mean_sat(ent_q.sum_imag[47], quo);
				default: wt_q <= (ent_q.var_sum == '0) ? 32'h0 :
					((quo[63:32] != '0) ? 32'hFFFF_FFFF : quo[31:0]);
			endcase
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			rsp_q.out_stack_index <= req_q.stack_index;
			rsp_q.mean_real       <= mre_q;
			rsp_q.mean_imag       <= mim_q;
			rsp_q.stack_weight    <= wt_q;
			rsp_q.product_count   <= ent_q.count;
		end
	end

	assign rsp         = rsp_q;
	assign st.is_drain = (req.req_type == RBS_REQ_DRAIN);
	assign st.acc_skip = (req.weight == '0) | !in_range_new;
	assign st.clr_last = (clr_q == AW'(DEPTH - 1));
	assign st.div_busy = div_busy;
	assign st.div_done = div_done;

endmodule

### rtl/rbs_ctrl.sv
// ----------------------------------------------------------------------------
// rbs_ctrl
// Controller: clear pass, request sequencing, divider schedule, output valid.
// ----------------------------------------------------------------------------
module rbs_ctrl
	import rbs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	input  rbs_stat_t st,
	output rbs_cmd_t  cmd
);

	rbs_state_t state_q, state_d;
	rbs_div_t   sel_q, sel_d;
	logic       rsp_valid_q;

	// state and output valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			sel_q       <= DIV_RCP;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// next state and commands
	always_comb begin
		state_d     = state_q;
		sel_d       = sel_q;
		cmd         = '0;
		cmd.div_sel = sel_q;
		req_ready   = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_we = 1'b1;
				if (st.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.take = 1'b1;
					if (st.is_drain) begin
						state_d = ST_DRN_RD;
					end else if (!st.acc_skip) begin
						sel_d   = DIV_RCP;
						state_d = ST_DIV_GO;
					end
				end
			end
			ST_ACC_RD: begin
				cmd.rd  = 1'b1;
				state_d = ST_ACC_WR;
			end
			ST_ACC_WR: begin
				cmd.acc_we = 1'b1;
				state_d    = ST_IDLE;
			end
			ST_DRN_RD: begin
				cmd.rd  = 1'b1;
				state_d = ST_DRN_LATCH;
			end
			ST_DRN_LATCH: begin
				cmd.latch = 1'b1;
				sel_d     = DIV_RE;
				state_d   = ST_DIV_GO;
			end
			ST_DIV_GO: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV_RUN;
			end
			ST_DIV_RUN: begin
				if (st.div_done) begin
					cmd.div_cap = 1'b1;
					unique case (sel_q)
						DIV_RCP: state_d = ST_ACC_RD;
						DIV_RE: begin
							sel_d   = DIV_IM;
							state_d = ST_DIV_GO;
						end
						DIV_IM: begin
							sel_d   = DIV_WT;
							state_d = ST_DIV_GO;
						end
						default: state_d = ST_FIN;
					endcase
				end
			end
			ST_FIN: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	assign rsp_valid = rsp_valid_q;

`ifndef SYNTH
	// divider is never restarted while running
	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !st.div_busy)
		else $error("divider started while busy");

	// a finished divide always moves the sequence on
	a_div_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV_RUN && st.div_done) |=> (state_q != ST_DIV_RUN))
		else $error("divide result not consumed");

	// a waiting result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!rsp_valid_q || rsp_ready))
		else $error("output register overwritten");

	// memory writes never collide with reads of the same request step
	a_rd_wr_apart: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |-> !(cmd.acc_we || cmd.clr_we || cmd.latch))
		else $error("read and write in one step");
`endif

endmodule
